// ===== rtl/dsr_pkg.sv =====
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types and codes for the graph store with reachability walks.
// ----------------------------------------------------------------------------
package dsr_pkg;

    typedef enum logic [2:0] {
        CMD_ADD_NODE  = 3'd0,
        CMD_ADD_EDGE  = 3'd1,
        CMD_DEL_EDGE  = 3'd2,
        CMD_DEL_NODE  = 3'd3,
        CMD_WALK_DOWN = 3'd4,
        CMD_WALK_UP   = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_MISSING = 3'd1,
        ST_EXISTS  = 3'd2,
        ST_NO_EDGE = 3'd3,
        ST_DANGLE  = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_DEL_RD,
        S_DEL_ROW,
        S_DEL_CHK,
        S_DEL_SWEEP_RD,
        S_DEL_SWEEP_WR,
        S_WALK_PICK,
        S_WALK_RD,
        S_WALK_MERGE,
        S_OUT
    } t_state;

endpackage

// ===== rtl/dsr_ram.sv =====
// ----------------------------------------------------------------------------
// dsr_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/dag_store_with_reachability_top.sv =====
// ----------------------------------------------------------------------------
// dag_store_with_reachability_top
// Directed graph store: adjacency rows in two RAMs, edits and walks.
// ----------------------------------------------------------------------------
// One command is handled at a time. After reset a clearing pass writes zero
// to all MAX_NODES rows of both adjacency RAMs, during which no command is
// taken. Add node and the unused codes answer from the idle state; edge
// commands read both rows, check them and write them back when the edit
// applies. Remove node, when force is clear, reads the in-row of each
// target, then sweeps every row with one read-modify-write each; a walk
// reads the row of each reached node and merges it. The rate is set by the
// single read port of each adjacency RAM. Results sit in an output register
// and are held until taken; the next command is taken the cycle after the
// result is gone.
module dag_store_with_reachability_top #(
    parameter int MAX_NODES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [5:0]  i_node_a,
    input  logic [5:0]  i_node_b,
    input  logic        i_force_req,
    input  logic [63:0] i_start_set,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [6:0]  o_new_node,
    output logic [63:0] o_reach_set
);
    localparam int AW = $clog2(MAX_NODES);

    dsr_pkg::t_state r_state, n_state;

    logic [MAX_NODES-1:0] r_alive, n_alive;
    logic [6:0]           r_count, n_count;
    logic [MAX_NODES-1:0] r_reached, n_reached;
    logic [MAX_NODES-1:0] r_frontier, n_frontier;
    logic [MAX_NODES-1:0] r_targets, n_targets;
    logic [AW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_a, n_a, r_b, n_b;
    logic                 r_force, n_force;
    logic [2:0]           r_cmd, n_cmd;
    logic                 r_aok, n_aok, r_bok, n_bok;
    logic [MAX_NODES-1:0] r_orow, n_orow;
    logic                 r_ovalid, n_ovalid;
    logic [2:0]           r_ostat, n_ostat;
    logic [6:0]           r_onew, n_onew;
    logic [63:0]          r_oreach, n_oreach;

    logic                 out_we, in_we;
    logic [AW-1:0]        out_wa, in_wa, out_ra, in_ra;
    logic [MAX_NODES-1:0] out_wd, in_wd, out_rd, in_rd;

    dsr_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_out_rows (
        .i_clk(i_clk), .i_we(out_we), .i_waddr(out_wa), .i_wdata(out_wd),
        .i_raddr(out_ra), .o_rdata(out_rd)
    );
    dsr_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_in_rows (
        .i_clk(i_clk), .i_we(in_we), .i_waddr(in_wa), .i_wdata(in_wd),
        .i_raddr(in_ra), .o_rdata(in_rd)
    );

    logic [MAX_NODES-1:0] a_bit, b_bit, low_bit;
    logic [AW-1:0]        low_idx;
    logic                 in_few;
    logic                 a_in, b_in;

    assign a_bit   = MAX_NODES'(1) << r_a;
    assign b_bit   = MAX_NODES'(1) << r_b;
    assign in_few  = (in_rd & (in_rd - MAX_NODES'(1))) == '0;
    // lowest set bit of the active mask (frontier or remaining targets)
    always_comb begin
        logic [MAX_NODES-1:0] m;
        m = (r_state == dsr_pkg::S_WALK_PICK) ? r_frontier : r_targets;
        low_bit = m & (~m + MAX_NODES'(1));
        low_idx = '0;
        for (int k = 0; k < MAX_NODES; k++) begin
            if (low_bit[k]) begin
                low_idx = AW'(k);
            end
        end
    end

    // node ids wider than the store are never valid
    assign a_in = (7'(i_node_a) < 7'(MAX_NODES)) && (7'(i_node_a) < r_count) &&
                  r_alive[i_node_a[AW-1:0]];
    assign b_in = (7'(i_node_b) < 7'(MAX_NODES)) && (7'(i_node_b) < r_count) &&
                  r_alive[i_node_b[AW-1:0]];

    assign o_ready     = (r_state == dsr_pkg::S_IDLE) && !r_ovalid;
    assign o_valid     = r_ovalid;
    assign o_status    = r_ostat;
    assign o_new_node  = r_onew;
    assign o_reach_set = r_oreach;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dsr_pkg::S_CLEAR;
            r_alive  <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_alive  <= n_alive;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
        r_reached  <= n_reached;
        r_frontier <= n_frontier;
        r_targets  <= n_targets;
        r_a        <= n_a;
        r_b        <= n_b;
        r_force    <= n_force;
        r_cmd      <= n_cmd;
        r_aok      <= n_aok;
        r_bok      <= n_bok;
        r_orow     <= n_orow;
        r_ostat    <= n_ostat;
        r_onew     <= n_onew;
        r_oreach   <= n_oreach;
    end

    always_comb begin
        n_state = r_state;  n_alive = r_alive;  n_count = r_count;
        n_reached = r_reached;  n_frontier = r_frontier;  n_targets = r_targets;
        n_idx = r_idx;  n_a = r_a;  n_b = r_b;  n_force = r_force;  n_cmd = r_cmd;
        n_aok = r_aok;  n_bok = r_bok;  n_orow = r_orow;
        n_ovalid = r_ovalid && !i_ready;
        n_ostat = r_ostat;  n_onew = r_onew;  n_oreach = r_oreach;
        out_we = 1'b0;  in_we = 1'b0;
        out_wa = r_a;   in_wa = r_b;
        out_wd = '0;    in_wd = '0;
        out_ra = r_a;   in_ra = r_b;

        unique case (r_state)
            dsr_pkg::S_CLEAR: begin
                out_we = 1'b1;  in_we = 1'b1;
                out_wa = r_idx; in_wa = r_idx;
                n_idx  = r_idx + AW'(1);
                if (32'(r_idx) == MAX_NODES - 1) begin
                    n_state = dsr_pkg::S_IDLE;
                end
            end
            dsr_pkg::S_IDLE: begin
                n_a = i_node_a[AW-1:0];  n_b = i_node_b[AW-1:0];
                n_force = i_force_req;   n_cmd = i_command;
                n_aok = a_in;            n_bok = b_in;
                out_ra = i_node_a[AW-1:0];
                in_ra  = i_node_b[AW-1:0];
                if (i_valid && o_ready) begin
                    n_ostat = dsr_pkg::ST_DONE;
                    n_oreach = '0;
                    case (i_command)
                        dsr_pkg::CMD_ADD_NODE: begin
                            n_onew = r_count;
                            if (r_count >= 7'(MAX_NODES)) begin
                                n_ostat = dsr_pkg::ST_FULL;
                            end else begin
                                // rows of a fresh id are still zero: ids never reused
                                n_alive = r_alive | (MAX_NODES'(1) << r_count[AW-1:0]);
                                n_count = r_count + 7'd1;
                            end
                            n_ovalid = 1'b1;
                        end
                        dsr_pkg::CMD_ADD_EDGE, dsr_pkg::CMD_DEL_EDGE:
                            n_state = dsr_pkg::S_EDGE_RD;
                        dsr_pkg::CMD_DEL_NODE:
                            n_state = dsr_pkg::S_DEL_RD;
                        dsr_pkg::CMD_WALK_DOWN, dsr_pkg::CMD_WALK_UP: begin
                            n_reached  = i_start_set[MAX_NODES-1:0] & r_alive;
                            n_frontier = i_start_set[MAX_NODES-1:0] & r_alive;
                            n_state    = dsr_pkg::S_WALK_PICK;
                        end
                        default: begin
                            n_onew = r_count;
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            dsr_pkg::S_EDGE_RD: begin
                // rows of a and b are on the read ports now
                n_orow  = out_rd;
                n_state = dsr_pkg::S_EDGE_CHK;
                out_ra = r_a;  in_ra = r_b;
                if (!r_aok || !r_bok) begin
                    n_ostat = dsr_pkg::ST_MISSING;
                    n_state = dsr_pkg::S_OUT;
                end else if (r_cmd == dsr_pkg::CMD_ADD_EDGE) begin
                    if ((out_rd & b_bit) != '0) begin
                        n_ostat = dsr_pkg::ST_EXISTS;
                    end else begin
                        out_we = 1'b1;  out_wd = out_rd | b_bit;
                        in_we  = 1'b1;  in_wd  = in_rd | a_bit;
                    end
                    n_state = dsr_pkg::S_OUT;
                end else begin
                    if ((out_rd & b_bit) == '0) begin
                        n_ostat = dsr_pkg::ST_NO_EDGE;
                    end else if (!r_force && in_few) begin
                        n_ostat = dsr_pkg::ST_DANGLE;
                    end else begin
                        out_we = 1'b1;  out_wd = out_rd & ~b_bit;
                        in_we  = 1'b1;  in_wd  = in_rd & ~a_bit;
                    end
                    n_state = dsr_pkg::S_OUT;
                end
            end
            dsr_pkg::S_EDGE_CHK: n_state = dsr_pkg::S_OUT;
            dsr_pkg::S_DEL_RD: begin
                n_targets = out_rd;
                if (!r_aok) begin
                    n_ostat = dsr_pkg::ST_MISSING;
                    n_state = dsr_pkg::S_OUT;
                end else if (r_force || out_rd == '0) begin
                    n_idx   = '0;
                    n_state = dsr_pkg::S_DEL_SWEEP_RD;
                end else begin
                    n_state = dsr_pkg::S_DEL_ROW;
                end
            end
            dsr_pkg::S_DEL_ROW: begin
                // read in-row of the lowest remaining target
                in_ra = low_idx;
                n_idx = low_idx;
                n_targets = r_targets & ~low_bit;
                n_state = dsr_pkg::S_DEL_CHK;
            end
            dsr_pkg::S_DEL_CHK: begin
                if (in_few) begin
                    n_ostat = dsr_pkg::ST_DANGLE;
                    n_state = dsr_pkg::S_OUT;
                end else if (r_targets == '0) begin
                    n_idx   = '0;
                    n_state = dsr_pkg::S_DEL_SWEEP_RD;
                end else begin
                    n_state = dsr_pkg::S_DEL_ROW;
                end
            end
            dsr_pkg::S_DEL_SWEEP_RD: begin
                out_ra = r_idx;  in_ra = r_idx;
                n_state = dsr_pkg::S_DEL_SWEEP_WR;
            end
            dsr_pkg::S_DEL_SWEEP_WR: begin
                out_we = 1'b1;  in_we = 1'b1;
                out_wa = r_idx; in_wa = r_idx;
                out_wd = (r_idx == r_a) ? '0 : (out_rd & ~a_bit);
                in_wd  = (r_idx == r_a) ? '0 : (in_rd & ~a_bit);
                n_idx  = r_idx + AW'(1);
                if (32'(r_idx) == MAX_NODES - 1) begin
                    n_alive = r_alive & ~a_bit;
                    n_state = dsr_pkg::S_OUT;
                end else begin
                    n_state = dsr_pkg::S_DEL_SWEEP_RD;
                end
            end
            dsr_pkg::S_WALK_PICK: begin
                if (r_frontier == '0) begin
                    n_oreach = 64'(r_reached);
                    n_state  = dsr_pkg::S_OUT;
                end else begin
                    out_ra = low_idx;  in_ra = low_idx;
                    n_frontier = r_frontier & ~low_bit;
                    n_idx   = low_idx;
                    n_state = dsr_pkg::S_WALK_RD;
                end
            end
            dsr_pkg::S_WALK_RD: begin
                n_orow  = (r_cmd == dsr_pkg::CMD_WALK_DOWN) ? out_rd : in_rd;
                n_state = dsr_pkg::S_WALK_MERGE;
            end
            dsr_pkg::S_WALK_MERGE: begin
                n_reached  = r_reached | (r_orow & r_alive);
                n_frontier = r_frontier | (r_orow & r_alive & ~r_reached);
                n_state    = dsr_pkg::S_WALK_PICK;
            end
            dsr_pkg::S_OUT: begin
                n_onew   = r_count;
                n_ovalid = 1'b1;
                n_state  = dsr_pkg::S_IDLE;
            end
            default: n_state = dsr_pkg::S_IDLE;
        endcase
    end

    // result is never dropped while held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_reach_set))
        else $error("result changed while stalled");
    // no command taken while a result waits
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while result pending");
    // node count only grows by one
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == $past(r_count) || r_count == $past(r_count) + 7'd1)
        else $error("node count jumped");
    // walk results only hold live nodes
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reach_set[MAX_NODES-1:0] & ~r_alive) == '0)
        else $error("dead node reached");
endmodule

// ===== tb/sv/dag_store_with_reachability_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dag_store_with_reachability_top_tb
// Drives graph edits and walks into the store and checks every response
// against a bit-accurate software copy of the graph kept in the bench.
// ----------------------------------------------------------------------------
module dag_store_with_reachability_top_tb;

    localparam int NODES = 64;
    // command codes with no operation behind them
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_command;
    logic [5:0]  i_node_a;
    logic [5:0]  i_node_b;
    logic        i_force_req;
    logic [63:0] i_start_set;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [6:0]  o_new_node;
    logic [63:0] o_reach_set;

    dag_store_with_reachability_top #(.MAX_NODES(NODES)) i_dut (.*);

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  new_node;
        logic [63:0] reach_set;
    } t_resp;

    // shadow graph
    logic [63:0] succ_rows [NODES];
    logic [63:0] pred_rows [NODES];
    logic [63:0] live_mask;
    int          num_nodes;

    t_resp resp_q[$];
    int    err_cnt;
    bit    rx_idle_en;
    bit    long_hold_req;
    int    rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #80ms;
        $display("FAIL");
        $finish;
    end

    function automatic bit node_ok(int id);
        return id < num_nodes && live_mask[id];
    endfunction

    function automatic bit under_two(logic [63:0] row);
        return (row & (row - 64'd1)) == 64'd0;
    endfunction

    function automatic logic [63:0] reach_from(logic [63:0] starts, bit down);
        logic [63:0] seen, front, fresh;
        int cur;
        seen = starts & live_mask;
        front = seen;
        while (front != 0) begin
            cur = 0;
            while (!front[cur]) cur++;
            front[cur] = 1'b0;
            fresh = (down ? succ_rows[cur] : pred_rows[cur]) & live_mask & ~seen;
            seen |= fresh;
            front |= fresh;
        end
        return seen;
    endfunction

    function automatic t_resp graph_apply(logic [2:0] cmd, int a, int b, bit frc,
                                          logic [63:0] starts);
        t_resp r;
        r = '0;
        r.status = dsr_pkg::ST_DONE;
        case (cmd)
            dsr_pkg::CMD_ADD_NODE: begin
                if (num_nodes >= NODES) begin
                    r.status = dsr_pkg::ST_FULL;
                end else begin
                    succ_rows[num_nodes] = '0;
                    pred_rows[num_nodes] = '0;
                    live_mask[num_nodes] = 1'b1;
                    num_nodes++;
                    r.new_node = 7'(num_nodes - 1);
                    return r;
                end
            end
            dsr_pkg::CMD_ADD_EDGE: begin
                if (!node_ok(a) || !node_ok(b)) r.status = dsr_pkg::ST_MISSING;
                else if (succ_rows[a][b]) r.status = dsr_pkg::ST_EXISTS;
                else begin
                    succ_rows[a][b] = 1'b1;
                    pred_rows[b][a] = 1'b1;
                end
            end
            dsr_pkg::CMD_DEL_EDGE: begin
                if (!node_ok(a) || !node_ok(b)) r.status = dsr_pkg::ST_MISSING;
                else if (!succ_rows[a][b]) r.status = dsr_pkg::ST_NO_EDGE;
                else if (!frc && under_two(pred_rows[b])) r.status = dsr_pkg::ST_DANGLE;
                else begin
                    succ_rows[a][b] = 1'b0;
                    pred_rows[b][a] = 1'b0;
                end
            end
            dsr_pkg::CMD_DEL_NODE: begin
                if (!node_ok(a)) begin
                    r.status = dsr_pkg::ST_MISSING;
                end else begin
                    if (!frc)
                        for (int t = 0; t < NODES; t++)
                            if (succ_rows[a][t] && under_two(pred_rows[t]))
                                r.status = dsr_pkg::ST_DANGLE;
                    if (r.status == dsr_pkg::ST_DONE) begin
                        for (int j = 0; j < NODES; j++) begin
                            succ_rows[j][a] = 1'b0;
                            pred_rows[j][a] = 1'b0;
                        end
                        succ_rows[a] = '0;
                        pred_rows[a] = '0;
                        live_mask[a] = 1'b0;
                    end
                end
            end
            dsr_pkg::CMD_WALK_DOWN: r.reach_set = reach_from(starts, 1'b1);
            dsr_pkg::CMD_WALK_UP:   r.reach_set = reach_from(starts, 1'b0);
            default: ;
        endcase
        r.new_node = 7'(num_nodes);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // one command transaction; gap_max 0 means back to back
    task automatic send_cmd(logic [2:0] cmd, int a, int b, bit frc,
                            logic [63:0] starts, int gap_max);
        int gap;
        if (gap_max > 0 && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, gap_max);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_node_a    <= 6'(a);
        i_node_b    <= 6'(b);
        i_force_req <= frc;
        i_start_set <= starts;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        resp_q = {resp_q, graph_apply(cmd, a, b, frc, starts)};
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (resp_q.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stalls, or a long hold when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (resp_q.size() == 0) begin
                    report_mismatch("unexpected result", o_status, 0);
                end else begin
                    t_resp w;
                    w = resp_q.pop_front();
                    if (o_status !== w.status)
                        report_mismatch("status", o_status, w.status);
                    if (o_new_node !== w.new_node)
                        report_mismatch("new_node", o_new_node, w.new_node);
                    if (o_reach_set !== w.reach_set)
                        report_mismatch("reach_set", o_reach_set, w.reach_set);
                end
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rx_hold <= 300;
                i_ready <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                i_ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                rx_hold <= $urandom_range(0, 10);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int pick_node();
        if (num_nodes > 0 && $urandom_range(0, 9) != 0)
            return $urandom_range(0, num_nodes - 1);
        return $urandom_range(0, 63);
    endfunction

    task automatic test_directed();
        send_cmd(dsr_pkg::CMD_WALK_DOWN, 0, 0, 0, '1, 0);   // empty graph
        send_cmd(dsr_pkg::CMD_ADD_EDGE, 0, 1, 0, '0, 0);    // missing nodes
        for (int i = 0; i < 4; i++) send_cmd(dsr_pkg::CMD_ADD_NODE, 0, 0, 0, '0, 0);
        send_cmd(dsr_pkg::CMD_ADD_EDGE, 0, 1, 0, '0, 0);
        send_cmd(dsr_pkg::CMD_ADD_EDGE, 0, 1, 0, '0, 0);    // duplicate
        send_cmd(dsr_pkg::CMD_ADD_EDGE, 2, 1, 0, '0, 0);
        send_cmd(dsr_pkg::CMD_ADD_EDGE, 1, 1, 0, '0, 0);    // self loop
        send_cmd(dsr_pkg::CMD_ADD_EDGE, 1, 3, 0, '0, 0);
        send_cmd(dsr_pkg::CMD_DEL_EDGE, 3, 0, 0, '0, 0);    // edge missing
        send_cmd(dsr_pkg::CMD_DEL_EDGE, 1, 3, 0, '0, 0);    // would dangle
        send_cmd(dsr_pkg::CMD_DEL_NODE, 1, 0, 0, '0, 0);    // would dangle
        send_cmd(dsr_pkg::CMD_WALK_DOWN, 0, 0, 0, 64'h8000_0000_0000_0001, 0);
        send_cmd(dsr_pkg::CMD_WALK_UP, 0, 0, 0, 64'h8, 0);
        send_cmd(dsr_pkg::CMD_DEL_EDGE, 0, 1, 0, '0, 0);
        send_cmd(dsr_pkg::CMD_DEL_EDGE, 1, 3, 1, '0, 0);    // forced
        send_cmd(dsr_pkg::CMD_DEL_NODE, 3, 0, 0, '0, 0);    // no out edges
        send_cmd(dsr_pkg::CMD_DEL_NODE, 2, 0, 1, '0, 0);
        send_cmd(dsr_pkg::CMD_DEL_NODE, 63, 63, 1, '0, 0);
        send_cmd(CMD_SPARE_LO, 63, 63, 1, '1, 0);
        send_cmd(CMD_SPARE_HI, 0, 0, 0, '0, 0);
        send_cmd(dsr_pkg::CMD_WALK_UP, 0, 0, 0, '1, 0);
        drop_valid();
    endtask

    task automatic random_cmd(int gap_max);
        int r;
        logic [63:0] s;
        r = $urandom_range(0, 99);
        s = (num_nodes > 0 && $urandom_range(0, 3) != 0) ?
            (64'd1 << $urandom_range(0, num_nodes - 1)) : rand64();
        if (r < 10)      send_cmd(dsr_pkg::CMD_ADD_NODE, $urandom_range(0, 63),
                                  $urandom_range(0, 63), $urandom_range(0, 1),
                                  rand64(), gap_max);
        else if (r < 45) send_cmd(dsr_pkg::CMD_ADD_EDGE, pick_node(), pick_node(), 0, '0,
                                  gap_max);
        else if (r < 60) send_cmd(dsr_pkg::CMD_DEL_EDGE, pick_node(), pick_node(),
                                  $urandom_range(0, 1), '0, gap_max);
        else if (r < 66) send_cmd(dsr_pkg::CMD_DEL_NODE, pick_node(), $urandom_range(0, 63),
                                  $urandom_range(0, 3) == 0, '0, gap_max);
        else if (r < 82) send_cmd(dsr_pkg::CMD_WALK_DOWN, 0, 0, 0, s, gap_max);
        else if (r < 98) send_cmd(dsr_pkg::CMD_WALK_UP, 0, 0, 0, s, gap_max);
        else             send_cmd(($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO,
                                  $urandom_range(0, 63), $urandom_range(0, 63),
                                  $urandom_range(0, 1), s, gap_max);
    endtask

    task automatic test_random(int n, int gap_max);
        for (int i = 0; i < n; i++) random_cmd(gap_max);
        drop_valid();
    endtask

    // fill to capacity, then ask for one more node
    task automatic test_store_full();
        while (num_nodes < NODES) send_cmd(dsr_pkg::CMD_ADD_NODE, 0, 0, 0, '0, 11);
        send_cmd(dsr_pkg::CMD_ADD_NODE, 63, 63, 1, '1, 0);
        send_cmd(dsr_pkg::CMD_ADD_EDGE, 63, 0, 0, '0, 0);
        send_cmd(dsr_pkg::CMD_WALK_DOWN, 0, 0, 0, '1, 0);
        drop_valid();
    endtask

    task automatic test_backpressure();
        long_hold_req = 1'b1;
        test_random(30, 0);
        wait_drained();
    endtask

    initial begin
        err_cnt = 0;
        rx_idle_en = 1'b1;
        long_hold_req = 1'b0;
        rx_hold = 0;
        num_nodes = 0;
        live_mask = '0;
        for (int i = 0; i < NODES; i++) begin
            succ_rows[i] = '0;
            pred_rows[i] = '0;
        end
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = '0;
        i_node_a = '0;
        i_node_b = '0;
        i_force_req = 1'b0;
        i_start_set = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(500, 11);
        wait_drained();
        test_backpressure();
        test_store_full();
        test_random(700, 11);
        rx_idle_en = 1'b0;
        test_random(200, 0);

        wait_drained();
        repeat (400) @(posedge i_clk);
        if (err_cnt == 0 && resp_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
